// ===== src/clcd_pkg.sv =====
// Shared types and constants for the character LCD nibble sequencer.
package clcd_pkg;

  // Text buffer geometry
  localparam int COLUMNS    = 16;
  localparam int TBUF_DEPTH = 2 * COLUMNS;
  localparam int TBUF_AW    = $clog2(TBUF_DEPTH);

  // State widths
  localparam int IDX_W  = 4;
  localparam int LEFT_W = 5;

  // Configuration register indexes
  localparam int          NUM_INIT  = 6;
  localparam logic [2:0]  REG_DELAY = 3'd6;

  // Fixed command bytes
  localparam logic [7:0] LINE2_CMD = 8'hC0;
  localparam logic [7:0] HOME_CMD  = 8'h03;

  // Reset values of the configuration registers
  localparam logic [7:0] DELAY_RST = 8'd10;
  localparam logic [7:0] INIT_RST [NUM_INIT] = '{8'h33, 8'h32, 8'h28, 8'h08, 8'h01, 8'h06};

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_INIT   = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_CELL   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    PH_HIGH = 3'd0,
    PH_DOWN = 3'd1,
    PH_LOW  = 3'd2,
    PH_WAIT = 3'd3,
    PH_EXEC = 3'd4,
    PH_IDLE = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    SRC_INIT = 2'd0,
    SRC_TEXT = 2'd1,
    SRC_JUMP = 2'd2,
    SRC_HOME = 2'd3
  } byte_src_t;

  // Write request into the text buffer
  typedef struct packed {
    logic               en;
    logic [TBUF_AW-1:0] addr;
    logic [7:0]         data;
  } tbuf_wr_t;

endpackage

// ===== src/clcd_if.sv =====
// Valid/ready channel interfaces for sequencer requests and pin results.
interface clcd_in_if;
  import clcd_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic       row;
  logic [3:0] column;
  logic [7:0] char_code;

  modport source (output valid, cmd, row, column, char_code, input ready);
  modport sink   (input valid, cmd, row, column, char_code, output ready);
endinterface

interface clcd_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] data_nibble;
  logic       lcd_enable;
  logic       reg_select;
  logic       busy_res;

  modport source (output valid, data_nibble, lcd_enable, reg_select, busy_res, input ready);
  modport sink   (input valid, data_nibble, lcd_enable, reg_select, busy_res, output ready);
endinterface

// ===== src/clcd_text_buf.sv =====
// Two-row text buffer: one write port, one combinational read port.
module clcd_text_buf
  import clcd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  tbuf_wr_t           wr,
  input  logic [TBUF_AW-1:0] rd_addr,
  output logic [7:0]         rd_data
);

  logic [7:0] cells_r [TBUF_DEPTH];

  // Clear on reset, store cell writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TBUF_DEPTH; i++) begin
        cells_r[i] <= '0;
      end
    end else if (wr.en) begin
      cells_r[wr.addr] <= wr.data;
    end
  end

  assign rd_data = cells_r[rd_addr];

endmodule

// ===== src/char_lcd_nibble_sequencer_core.sv =====
// Top level of the character LCD nibble sequencer.
//
//   channel | dir | transfer content
//   --------+-----+---------------------------------------------------
//   in_ch   | in  | cmd, row, column, char_code (tick, request, cell write)
//   out_ch  | out | data_nibble, lcd_enable, reg_select, busy_res
//   cfg_*   | in  | cfg_we, cfg_index, cfg_data (init bytes, delay_ticks)
//
// Every input transfer is processed as it is accepted; its result sits in the
// output register the next cycle. One item per cycle is sustained while
// out_ch.ready is high; a stalled result holds the input off only when the
// output register is full and not being drained. Reset (rst_n, synchronous)
// clears the sequencer to idle, restores the configuration defaults and
// zeroes the text buffer in the same cycle.
module char_lcd_nibble_sequencer_core
  import clcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  clcd_in_if.sink     in_ch,
  clcd_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  // Configuration registers
  logic [7:0] init_cmd_r [NUM_INIT];
  logic [7:0] delay_ticks_r;

  // Sequencer state
  phase_t              phase_r, phase_nxt;
  phase_t              after_r, after_nxt;
  phase_t              ret_r, ret_nxt;
  logic [7:0]          dcount_r, dcount_nxt;
  logic [LEFT_W-1:0]   left_r, left_nxt;
  byte_src_t           src_r, src_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic                row2_r, row2_nxt;
  logic                jump_r, jump_nxt;
  logic                rs_r, rs_nxt;
  logic                en_r, en_nxt;
  logic [3:0]          nib_r, nib_nxt;

  // Output register
  logic       out_valid_r;
  logic [3:0] out_nib_r;
  logic       out_en_r, out_rs_r, out_busy_r;

  logic               in_fire;
  cmd_t               cmd;
  tbuf_wr_t           tbuf_wr;
  logic [TBUF_AW-1:0] rd_addr;
  logic [7:0]         rd_data;
  logic [7:0]         cur_byte;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign cmd         = cmd_t'(in_ch.cmd);

  // Cell write address: row selects the upper half
  always_comb begin
    tbuf_wr.en   = in_fire && (cmd == CMD_CELL) && ({1'b0, in_ch.column} < 5'(COLUMNS));
    tbuf_wr.addr = (in_ch.row ? TBUF_AW'(COLUMNS) : '0) + TBUF_AW'(in_ch.column);
    tbuf_wr.data = in_ch.char_code;
  end

  assign rd_addr = (row2_r ? TBUF_AW'(COLUMNS) : '0) + TBUF_AW'(idx_r);

  clcd_text_buf u_tbuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (tbuf_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Select the byte being sent
  always_comb begin
    unique case (src_r)
      SRC_INIT: cur_byte = ({1'b0, idx_r} < 5'(NUM_INIT)) ? init_cmd_r[idx_r[2:0]] : 8'h00;
      SRC_TEXT: cur_byte = ({1'b0, idx_r} < 5'(COLUMNS)) ? rd_data : 8'h00;
      SRC_JUMP: cur_byte = LINE2_CMD;
      SRC_HOME: cur_byte = HOME_CMD;
      default:  cur_byte = 8'h00;
    endcase
  end

  // Next state for one transfer
  always_comb begin
    phase_nxt  = phase_r;
    after_nxt  = after_r;
    ret_nxt    = ret_r;
    dcount_nxt = dcount_r;
    left_nxt   = left_r;
    src_nxt    = src_r;
    idx_nxt    = idx_r;
    row2_nxt   = row2_r;
    jump_nxt   = jump_r;
    rs_nxt     = rs_r;
    en_nxt     = en_r;
    nib_nxt    = nib_r;

    unique case (cmd)
      CMD_TICK: begin
        unique case (phase_r)
          PH_HIGH: begin
            nib_nxt   = cur_byte[7:4];
            ret_nxt   = PH_LOW;
            after_nxt = PH_DOWN;
            phase_nxt = PH_WAIT;
            en_nxt    = 1'b1;
          end
          PH_DOWN: begin
            en_nxt    = 1'b0;
            after_nxt = ret_r;
            phase_nxt = PH_WAIT;
          end
          PH_LOW: begin
            nib_nxt   = cur_byte[3:0];
            ret_nxt   = PH_EXEC;
            after_nxt = PH_DOWN;
            phase_nxt = PH_WAIT;
            en_nxt    = 1'b1;
          end
          PH_WAIT: begin
            if (dcount_r == 8'd0) begin
              dcount_nxt = delay_ticks_r;
              phase_nxt  = after_r;
            end else begin
              dcount_nxt = dcount_r - 8'd1;
            end
          end
          PH_EXEC: begin
            phase_nxt = PH_WAIT;
            if (left_r > LEFT_W'(1)) begin
              // More bytes in this run
              left_nxt  = left_r - LEFT_W'(1);
              idx_nxt   = idx_r + IDX_W'(1);
              after_nxt = PH_HIGH;
            end else begin
              left_nxt = '0;
              priority if (rs_r) begin
                // Row done: follow with line jump or home
                rs_nxt    = 1'b0;
                after_nxt = PH_HIGH;
                left_nxt  = LEFT_W'(1);
                idx_nxt   = '0;
                if (row2_r) begin
                  row2_nxt = 1'b0;
                  jump_nxt = 1'b0;
                  src_nxt  = SRC_HOME;
                end else begin
                  jump_nxt = 1'b1;
                  src_nxt  = SRC_JUMP;
                end
              end else if (jump_r) begin
                // Line jump sent: start row 1
                jump_nxt  = 1'b0;
                row2_nxt  = 1'b1;
                src_nxt   = SRC_TEXT;
                left_nxt  = LEFT_W'(COLUMNS);
                idx_nxt   = '0;
                rs_nxt    = 1'b1;
                after_nxt = PH_HIGH;
              end else begin
                row2_nxt  = 1'b0;
                rs_nxt    = 1'b0;
                after_nxt = PH_IDLE;
              end
            end
          end
          default: ;
        endcase
      end
      CMD_INIT: begin
        if (phase_r == PH_IDLE) begin
          src_nxt   = SRC_INIT;
          left_nxt  = LEFT_W'(NUM_INIT);
          idx_nxt   = '0;
          row2_nxt  = 1'b0;
          jump_nxt  = 1'b0;
          rs_nxt    = 1'b0;
          phase_nxt = PH_HIGH;
        end
      end
      CMD_UPDATE: begin
        if (phase_r == PH_IDLE) begin
          src_nxt   = SRC_TEXT;
          left_nxt  = LEFT_W'(COLUMNS);
          idx_nxt   = '0;
          row2_nxt  = 1'b0;
          jump_nxt  = 1'b0;
          rs_nxt    = 1'b1;
          phase_nxt = PH_HIGH;
        end
      end
      CMD_CELL: ;
      default: ;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_INIT; i++) begin
        init_cmd_r[i] <= INIT_RST[i];
      end
      delay_ticks_r <= DELAY_RST;
    end else if (cfg_we) begin
      if (cfg_index < 3'(NUM_INIT)) begin
        init_cmd_r[cfg_index] <= cfg_data;
      end else if (cfg_index == REG_DELAY) begin
        delay_ticks_r <= cfg_data;
      end
    end
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      after_r  <= PH_HIGH;
      ret_r    <= PH_HIGH;
      dcount_r <= DELAY_RST;
      left_r   <= '0;
      src_r    <= SRC_INIT;
      idx_r    <= '0;
      row2_r   <= 1'b0;
      jump_r   <= 1'b0;
      rs_r     <= 1'b0;
      en_r     <= 1'b0;
      nib_r    <= '0;
    end else if (in_fire) begin
      phase_r  <= phase_nxt;
      after_r  <= after_nxt;
      ret_r    <= ret_nxt;
      dcount_r <= dcount_nxt;
      left_r   <= left_nxt;
      src_r    <= src_nxt;
      idx_r    <= idx_nxt;
      row2_r   <= row2_nxt;
      jump_r   <= jump_nxt;
      rs_r     <= rs_nxt;
      en_r     <= en_nxt;
      nib_r    <= nib_nxt;
    end
  end

  // Output valid: set on accept, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Capture the pin levels after this transfer's update
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_nib_r  <= nib_nxt;
      out_en_r   <= en_nxt;
      out_rs_r   <= rs_nxt;
      out_busy_r <= (phase_nxt != PH_IDLE);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.data_nibble = out_nib_r;
  assign out_ch.lcd_enable  = out_en_r;
  assign out_ch.reg_select  = out_rs_r;
  assign out_ch.busy_res    = out_busy_r;

`ifndef ASSERT_OFF
  // Strobe is never left high once the sequencer is back at idle
  a_en_busy: assert property (@(posedge clk) disable iff (!rst_n)
    en_r |-> (phase_r != PH_IDLE))
    else $error("enable high while idle");

  // Character data only ever comes from the text buffer
  a_rs_text: assert property (@(posedge clk) disable iff (!rst_n)
    rs_r |-> (src_r == SRC_TEXT))
    else $error("RS high on a command source");

  // Byte count never exceeds a row
  a_left_max: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= LEFT_W'(COLUMNS))
    else $error("byte count out of range");

  // An init request at idle starts the command run with RS low
  a_init_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (cmd == CMD_INIT) && (phase_r == PH_IDLE))
      |=> (phase_r == PH_HIGH) && !rs_r && (src_r == SRC_INIT))
    else $error("init request did not start sequence");

  // Every accepted item leaves a result in the output register
  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted item produced no result");
`endif

endmodule

// ===== dv/char_lcd_nibble_sequencer_checker.sv =====
// Checker for the LCD nibble sequencer: tracks accepted transfers and compares pin results.
module char_lcd_nibble_sequencer_checker
  import clcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  clcd_in_if         in_ch,
  clcd_out_if        out_ch,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         fail_count,
  output int         waiting
);

  typedef struct packed {
    logic [3:0] nibble;
    logic       strobe;
    logic       rs;
    logic       busy;
  } pins_t;

  // Shadow copy of the sequencer and its registers
  phase_t            seq_phase;
  phase_t            next_phase;
  phase_t            resume_phase;
  byte_src_t         src;
  logic [7:0]        delay_left;
  logic [LEFT_W-1:0] bytes_left;
  logic [IDX_W-1:0]  byte_idx;
  logic              on_row1;
  logic              jump_pending;
  logic              rs_q;
  logic              strobe_q;
  logic [3:0]        nibble_q;
  logic [7:0]        init_bytes [NUM_INIT];
  logic [7:0]        delay_cfg;
  logic [7:0]        text_mem [TBUF_DEPTH];
  pins_t             pins_due [$];
  int                errors = 0;

  // Byte currently selected for the bus
  function automatic logic [7:0] byte_on_bus();
    case (src)
      SRC_INIT: return (byte_idx < NUM_INIT) ? init_bytes[byte_idx] : 8'h00;
      SRC_TEXT: begin
        if (byte_idx < COLUMNS) return text_mem[(on_row1 ? COLUMNS : 0) + int'(byte_idx)];
        return 8'h00;
      end
      SRC_JUMP: return LINE2_CMD;
      default:  return HOME_CMD;
    endcase
  endfunction

  function automatic void load_single(input byte_src_t s);
    src        = s;
    bytes_left = LEFT_W'(1);
    byte_idx   = '0;
  endfunction

  // Close a byte: next byte, next segment of an update, or back to idle
  function automatic void finish_byte();
    seq_phase = PH_WAIT;
    if (bytes_left > 1) begin
      bytes_left--;
      byte_idx++;
      next_phase = PH_HIGH;
    end else begin
      bytes_left = '0;
      if (rs_q) begin
        rs_q       = 1'b0;
        next_phase = PH_HIGH;
        if (on_row1) begin
          on_row1      = 1'b0;
          jump_pending = 1'b0;
          load_single(SRC_HOME);
        end else begin
          jump_pending = 1'b1;
          load_single(SRC_JUMP);
        end
      end else if (jump_pending) begin
        jump_pending = 1'b0;
        on_row1      = 1'b1;
        src          = SRC_TEXT;
        bytes_left   = LEFT_W'(COLUMNS);
        byte_idx     = '0;
        rs_q         = 1'b1;
        next_phase   = PH_HIGH;
      end else begin
        on_row1    = 1'b0;
        rs_q       = 1'b0;
        next_phase = PH_IDLE;
      end
    end
  endfunction

  // Advance by one phase on a tick
  function automatic void tick_sequencer();
    logic [7:0] cur;
    cur = byte_on_bus();
    case (seq_phase)
      PH_HIGH: begin
        nibble_q     = cur[7:4];
        resume_phase = PH_LOW;
        next_phase   = PH_DOWN;
        seq_phase    = PH_WAIT;
        strobe_q     = 1'b1;
      end
      PH_DOWN: begin
        strobe_q   = 1'b0;
        next_phase = resume_phase;
        seq_phase  = PH_WAIT;
      end
      PH_LOW: begin
        nibble_q     = cur[3:0];
        resume_phase = PH_EXEC;
        next_phase   = PH_DOWN;
        seq_phase    = PH_WAIT;
        strobe_q     = 1'b1;
      end
      PH_WAIT: begin
        if (delay_left == 8'd0) begin
          delay_left = delay_cfg;
          seq_phase  = next_phase;
        end else begin
          delay_left--;
        end
      end
      PH_EXEC: finish_byte();
      default: ;
    endcase
  endfunction

  // Apply one item and return the pin levels it leaves behind
  function automatic pins_t predict_pins(input cmd_t c, input logic r, input logic [3:0] col,
                                         input logic [7:0] ch);
    pins_t p;
    case (c)
      CMD_TICK: tick_sequencer();
      CMD_INIT: begin
        if (seq_phase == PH_IDLE) begin
          src          = SRC_INIT;
          bytes_left   = LEFT_W'(NUM_INIT);
          byte_idx     = '0;
          on_row1      = 1'b0;
          jump_pending = 1'b0;
          rs_q         = 1'b0;
          seq_phase    = PH_HIGH;
        end
      end
      CMD_UPDATE: begin
        if (seq_phase == PH_IDLE) begin
          src          = SRC_TEXT;
          bytes_left   = LEFT_W'(COLUMNS);
          byte_idx     = '0;
          on_row1      = 1'b0;
          jump_pending = 1'b0;
          rs_q         = 1'b1;
          seq_phase    = PH_HIGH;
        end
      end
      default: begin
        if (col < COLUMNS) text_mem[int'(r) * COLUMNS + int'(col)] = ch;
      end
    endcase
    p.nibble = nibble_q;
    p.strobe = strobe_q;
    p.rs     = rs_q;
    p.busy   = (seq_phase < PH_IDLE);
    return p;
  endfunction

  task automatic compare_pin(input string name, input logic [3:0] want, input logic [3:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Track every transfer and configuration write in clock order
  always @(posedge clk) begin
    pins_t want;
    if (!rst_n) begin
      seq_phase    = PH_IDLE;
      next_phase   = PH_HIGH;
      resume_phase = PH_HIGH;
      src          = SRC_INIT;
      delay_left   = DELAY_RST;
      bytes_left   = '0;
      byte_idx     = '0;
      on_row1      = 1'b0;
      jump_pending = 1'b0;
      rs_q         = 1'b0;
      strobe_q     = 1'b0;
      nibble_q     = '0;
      init_bytes   = INIT_RST;
      delay_cfg    = DELAY_RST;
      foreach (text_mem[i]) text_mem[i] = 8'h00;
      pins_due.delete();
    end else begin
      // compare results against the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        if (pins_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual nibble %0h en %0b rs %0b %s",
                   $time, out_ch.data_nibble, out_ch.lcd_enable, out_ch.reg_select,
                   out_ch.busy_res ? "busy" : "idle");
        end else begin
          want = pins_due.pop_front();
          compare_pin("data_nibble", want.nibble, out_ch.data_nibble);
          compare_pin("lcd_enable", 4'(want.strobe), 4'(out_ch.lcd_enable));
          compare_pin("reg_select", 4'(want.rs), 4'(out_ch.reg_select));
          compare_pin("busy_res", 4'(want.busy), 4'(out_ch.busy_res));
        end
      end
      // predict each accepted item with the registers as they stood before this edge
      if (in_ch.valid && in_ch.ready)
        pins_due.push_back(predict_pins(cmd_t'(in_ch.cmd), in_ch.row, in_ch.column,
                                        in_ch.char_code));
      // register writes
      if (cfg_we) begin
        if (cfg_index < NUM_INIT) init_bytes[cfg_index] = cfg_data;
        else if (cfg_index == REG_DELAY) delay_cfg = cfg_data;
      end
    end
    waiting    <= pins_due.size();
    fail_count <= errors;
  end

endmodule

// ===== dv/char_lcd_nibble_sequencer_core_tb.sv =====
// Top of the LCD sequencer testbench: clock, reset, stimulus, receiver stalls and verdict.
module char_lcd_nibble_sequencer_core_tb;
  import clcd_pkg::*;

  localparam int         LIMIT       = 800_000;
  localparam int         HOLD_CYCLES = 300;
  localparam logic [2:0] REG_INIT0   = 3'd0;

  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;
  int         fail_count;
  int         waiting;
  int         cycles = 0;
  logic       squeeze_req = 1'b0;
  bit         tx_calm = 1'b0;
  bit         rx_calm = 1'b0;

  clcd_in_if  in_ch();
  clcd_out_if out_ch();

  char_lcd_nibble_sequencer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  char_lcd_nibble_sequencer_checker u_pin_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .waiting    (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Receiver: random stalls, calm stretches, and one long hold when asked
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (squeeze_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        squeeze_req = 1'b0;
      end else if (rx_calm) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
      if ($urandom_range(299) == 0) rx_calm = !rx_calm;
    end
  end

  // Offer one item and hold it until the transfer
  task automatic send_item(input cmd_t c, input logic r, input logic [3:0] col,
                           input logic [7:0] ch, input bit last);
    int gap;
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= c;
    in_ch.row       <= r;
    in_ch.column    <= col;
    in_ch.char_code <= ch;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    gap = (squeeze_req || tx_calm) ? 0 : pick_gap();
    if (last || gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Mostly ticks so that sequences run to the end, with requests and cell writes mixed in
  task automatic send_random(input bit last);
    int   r;
    cmd_t c;
    r = $urandom_range(99);
    if (r < 82) c = CMD_TICK;
    else if (r < 93) c = CMD_CELL;
    else if (r < 97) c = CMD_UPDATE;
    else c = CMD_INIT;
    send_item(c, 1'($urandom), 4'($urandom), 8'($urandom), last);
  endtask

  // Wait for every result, then let the block settle
  task automatic settle();
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Reprogram all registers while quiet, then run a stretch of random items
  task automatic run_phase(input logic [7:0] dly, input fill_t fill, input int n,
                           input bit squeeze);
    logic [7:0] val;
    settle();
    for (int k = 0; k < NUM_INIT; k++) begin
      case (fill)
        FILL_ZERO: val = 8'h00;
        FILL_ONES: val = 8'hFF;
        default:   val = 8'($urandom);
      endcase
      write_reg(REG_INIT0 + 3'(k), val);
    end
    write_reg(REG_DELAY, dly);
    cfg_we <= 1'b0;
    tx_calm = ($urandom_range(3) == 0);
    if (squeeze) squeeze_req = 1'b1;
    for (int i = 0; i < n; i++) send_random(i == n - 1);
  endtask

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.cmd       <= CMD_TICK;
    in_ch.row       <= 1'b0;
    in_ch.column    <= '0;
    in_ch.char_code <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: corner cells, tick while idle, init, ignored requests, write while busy
    send_item(CMD_CELL, 1'b0, 4'd0, 8'h00, 1'b0);
    send_item(CMD_CELL, 1'b1, 4'd15, 8'hFF, 1'b0);
    send_item(CMD_CELL, 1'b0, 4'd15, 8'h80, 1'b0);
    send_item(CMD_CELL, 1'b1, 4'd0, 8'h01, 1'b0);
    send_item(CMD_TICK, 1'b1, 4'd15, 8'hFF, 1'b0);
    send_item(CMD_INIT, 1'b0, 4'd0, 8'h00, 1'b0);
    send_item(CMD_UPDATE, 1'b0, 4'd0, 8'h00, 1'b0);
    send_item(CMD_INIT, 1'b1, 4'd7, 8'h55, 1'b0);
    send_item(CMD_CELL, 1'b0, 4'd1, 8'h7E, 1'b0);
    for (int i = 0; i < 14; i++)
      send_item(CMD_TICK, 1'($urandom), 4'($urandom), 8'($urandom), i == 13);

    // Random phases over several register settings
    run_phase(8'd0, FILL_RANDOM, 450, 1'b0);
    run_phase(8'd1, FILL_RANDOM, 350, 1'b1);
    run_phase(8'd255, FILL_ONES, 100, 1'b0);
    run_phase(8'd0, FILL_ZERO, 350, 1'b0);
    run_phase(8'($urandom_range(2)), FILL_RANDOM, 300, 1'b0);

    settle();
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
src/clcd_pkg.sv
src/clcd_if.sv
src/clcd_text_buf.sv
src/char_lcd_nibble_sequencer_core.sv
dv/char_lcd_nibble_sequencer_checker.sv
dv/char_lcd_nibble_sequencer_core_tb.sv
